/* rtl/rthsv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rthsv_pkg
// Shared types and constants of the RGB to HSV pixel pipeline.
// ----------------------------------------------------------------------------
package rthsv_pkg;

  localparam int unsigned ChanW    = 8;   // width of one color sample
  localparam int unsigned HueW     = 9;   // width of the hue in degrees
  localparam int unsigned QuoW     = 9;   // quotient bits, one per divider stage
  localparam int unsigned HNumW    = 17;  // 60 * 5 * 255 fits in 17 bits
  localparam int unsigned SNumW    = 16;  // 255 * 255 fits in 16 bits
  localparam int unsigned DivStages = QuoW;

  localparam logic [HueW-1:0] HueFull = HueW'(360);

  // Payload of one request while it walks through the divider stages.
  typedef struct packed {
    logic              last;
    logic [ChanW-1:0]  value;
    logic              hue_zero;  // gray pixel
    logic              hue_neg;   // hue quotient is negative
    logic              sat_zero;  // black pixel
    logic [HNumW-1:0]  h_rem;
    logic [HNumW-1:0]  h_div;
    logic [QuoW-1:0]   h_quo;
    logic [SNumW-1:0]  s_rem;
    logic [SNumW-1:0]  s_div;
    logic [QuoW-1:0]   s_quo;
  } div_t;

endpackage
`default_nettype wire

/* rtl/rthsv_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rthsv_front
// Two register stages: channel maximum, minimum and hue branch, then the
// hue and saturation numerators and divisors for the divider.
// ----------------------------------------------------------------------------
module rthsv_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic [7:0]              red_i,
  input  wire logic [7:0]              green_i,
  input  wire logic [7:0]              blue_i,
  input  wire logic                    last_i,
  output logic                         valid_o,
  output rthsv_pkg::div_t              data_o
);
  import rthsv_pkg::*;

  typedef enum logic [1:0] {
    BrRed,
    BrGreen,
    BrBlue
  } branch_e;

  // Stage A: extremes and branch.
  logic             a_valid_q;
  logic [ChanW-1:0] a_r_q, a_g_q, a_b_q, a_max_q, a_delta_q;
  logic             a_last_q;
  branch_e          a_br_q;

  logic [ChanW-1:0] max_d, min_d;
  branch_e          br_d;

  always_comb begin
    max_d = red_i;
    min_d = red_i;
    if (green_i > max_d) max_d = green_i;
    if (blue_i > max_d) max_d = blue_i;
    if (green_i < min_d) min_d = green_i;
    if (blue_i < min_d) min_d = blue_i;
    // Red wins ties, then green.
    if (red_i == max_d) begin
      br_d = BrRed;
    end else if (green_i == max_d) begin
      br_d = BrGreen;
    end else begin
      br_d = BrBlue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_r_q     <= red_i;
      a_g_q     <= green_i;
      a_b_q     <= blue_i;
      a_max_q   <= max_d;
      a_delta_q <= max_d - min_d;
      a_last_q  <= last_i;
      a_br_q    <= br_d;
    end
  end

  // Stage B: numerators. Only the red branch can have a negative difference.
  logic [10:0] mag;
  logic        neg;
  div_t        b_d;
  logic        b_valid_q;
  div_t        b_q;

  always_comb begin
    neg = 1'b0;
    unique case (a_br_q)
      BrRed: begin
        if (a_b_q > a_g_q) begin
          neg = 1'b1;
          mag = 11'(a_b_q) - 11'(a_g_q);
        end else begin
          mag = 11'(a_g_q) - 11'(a_b_q);
        end
      end
      BrGreen: mag = {2'b0, a_delta_q, 1'b0} + 11'(a_b_q) - 11'(a_r_q);
      BrBlue:  mag = {1'b0, a_delta_q, 2'b0} + 11'(a_r_q) - 11'(a_g_q);
      default: mag = '0;
    endcase

    b_d.last     = a_last_q;
    b_d.value    = a_max_q;
    b_d.hue_zero = (a_delta_q == '0);
    b_d.hue_neg  = neg;
    b_d.sat_zero = (a_max_q == '0);
    // 60 * mag as (64 - 4) * mag.
    b_d.h_rem    = {mag, 6'b0} - {4'b0, mag, 2'b0};
    // 255 * delta as 256 * delta - delta.
    b_d.s_rem    = {a_delta_q, 8'b0} - {8'b0, a_delta_q};
    // Divisors start aligned to the top quotient bit.
    b_d.h_div    = {1'b0, a_delta_q, 8'b0};
    b_d.s_div    = {a_max_q, 8'b0};
    b_d.h_quo    = '0;
    b_d.s_quo    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_q;

endmodule
`default_nettype wire

/* rtl/rthsv_div_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rthsv_div_stage
// One restoring division step for both the hue and saturation quotients,
// followed by a register.
// ----------------------------------------------------------------------------
module rthsv_div_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire rthsv_pkg::div_t     data_i,
  output logic                     valid_o,
  output rthsv_pkg::div_t          data_o
);
  import rthsv_pkg::*;

  logic h_ge, s_ge;
  div_t data_d;
  logic valid_q;
  div_t data_q;

  always_comb begin
    data_d = data_i;
    h_ge   = (data_i.h_rem >= data_i.h_div);
    s_ge   = (data_i.s_rem >= data_i.s_div);
    if (h_ge) data_d.h_rem = data_i.h_rem - data_i.h_div;
    if (s_ge) data_d.s_rem = data_i.s_rem - data_i.s_div;
    data_d.h_quo = {data_i.h_quo[QuoW-2:0], h_ge};
    data_d.s_quo = {data_i.s_quo[QuoW-2:0], s_ge};
    // The next step tries the next lower quotient bit.
    data_d.h_div = data_i.h_div >> 1;
    data_d.s_div = data_i.s_div >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* rtl/rthsv_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rthsv_back
// Wraps the signed hue quotient into 0..359, applies the gray and black
// pixel rules and holds the output register.
// ----------------------------------------------------------------------------
module rthsv_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire rthsv_pkg::div_t     data_i,
  output logic                     valid_o,
  output logic [8:0]               hue_o,
  output logic [7:0]               saturation_o,
  output logic [7:0]               value_o,
  output logic                     frame_end_o
);
  import rthsv_pkg::*;

  logic [HueW-1:0]  hue_d;
  logic [ChanW-1:0] sat_d;
  logic             valid_q;
  logic [HueW-1:0]  hue_q;
  logic [ChanW-1:0] sat_q, value_q;
  logic             last_q;

  always_comb begin
    // A negative quotient of zero magnitude is plain zero, not 360.
    priority if (data_i.hue_zero) begin
      hue_d = '0;
    end else if (data_i.hue_neg && (data_i.h_quo != '0)) begin
      hue_d = HueFull - data_i.h_quo;
    end else begin
      hue_d = data_i.h_quo;
    end
    sat_d = data_i.sat_zero ? '0 : data_i.s_quo[ChanW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      value_q <= data_i.value;
      last_q  <= data_i.last;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign value_o      = value_q;
  assign frame_end_o  = last_q;

endmodule
`default_nettype wire

/* rtl/rgb_to_hsv_pixel.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Converts one 8-bit RGB pixel per clock, while the receiver does not stall,
// into hue (degrees), saturation and value.
//
// Usage:
//   Requests enter on red_i, green_i, blue_i and last_pixel_i with the
//   in_valid_i / in_ready_o handshake. Results leave on hue_o,
//   saturation_o, value_o and frame_end_o with out_valid_o / out_ready_i.
//   frame_end_o is last_pixel_i of the same request.
//   From acceptance to out_valid_o a request passes two front stages
//   (extremes, numerators), nine divider stages that each settle one
//   quotient bit of both divisions, and one output stage. Throughput
//   is one request per cycle unless the receiver stalls; the nine-step
//   divider is fully pipelined, so every stage holds a different request.
//   Gray pixels give hue 0 and black pixels give saturation 0.
//   Reset clears every valid bit; the pipeline is empty afterwards.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_ready_o drops in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic       last_pixel_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [8:0]      hue_o,
  output logic [7:0]      saturation_o,
  output logic [7:0]      value_o,
  output logic            frame_end_o
);
  import rthsv_pkg::*;

  logic en;
  logic valid [DivStages+1];
  div_t data  [DivStages+1];

  // The pipeline moves unless a result sits at the output unclaimed.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rthsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .last_i  (last_pixel_i),
    .valid_o (valid[0]),
    .data_o  (data[0])
  );

  for (genvar i = 0; i < DivStages; i++) begin : g_div
    rthsv_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid[i]),
      .data_i  (data[i]),
      .valid_o (valid[i+1]),
      .data_o  (data[i+1])
    );
  end

  rthsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (valid[DivStages]),
    .data_i       (data[DivStages]),
    .valid_o      (out_valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .value_o      (value_o),
    .frame_end_o  (frame_end_o)
  );

  // Hue always wraps into whole degrees below a full turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_o < HueFull))
    else $error("hue out of range");

  // A black pixel has neither saturation nor hue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (value_o == '0)) |-> ((saturation_o == '0) && (hue_o == '0)))
    else $error("black pixel with nonzero saturation or hue");

  // Zero saturation means a gray pixel, whose hue is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (saturation_o == '0)) |-> (hue_o == '0))
    else $error("unsaturated pixel with nonzero hue");

  // The front stage output moves on only when the pipeline is enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && valid[0]) |=> valid[0])
    else $error("request lost during stall");

endmodule
`default_nettype wire
